/* hw/rtl/lsr_pkg.sv */
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared constants, register map and types of the long silence remover.
// ----------------------------------------------------------------------------
package lsr_pkg;

    // Default sizing, handed to the top level as parameter defaults.
    localparam int MAX_RUN_DEFAULT     = 4095;
    localparam int SAMPLE_BITS_DEFAULT = 24;

    // Fixed widths of the configuration registers.
    localparam int THR_W     = 23;
    localparam int RUN_REG_W = 12;
    localparam int CHAN_W    = 2;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RUN   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS  = 2'd2;

    // Reset values of the registers.
    localparam logic [THR_W-1:0]     THRESHOLD_RESET = '0;
    localparam logic [RUN_REG_W-1:0] MAX_RUN_RESET   = 12'd4095;
    localparam logic [CHAN_W-1:0]    CHANNELS_RESET  = 2'd2;

    // Channel count that tests channel 0 only.
    localparam logic [CHAN_W-1:0] CHANNELS_MONO = 2'd1;

    // Request kinds carried in the input tuser.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Register contents as seen by the datapath.
    typedef struct packed {
        logic [THR_W-1:0]     quiet_threshold;
        logic [RUN_REG_W-1:0] max_quiet_run;
        logic [CHAN_W-1:0]    channels_in_use;
    } lsr_cfg_t;

endpackage

/* hw/rtl/lsr_regs.sv */
// ----------------------------------------------------------------------------
// lsr_regs
// APB register file holding threshold, longest kept run and channel count.
// ----------------------------------------------------------------------------
module lsr_regs
    import lsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output lsr_cfg_t              cfg
);

    lsr_cfg_t               cfg_reg;
    lsr_cfg_t               cfg_next;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_THRESHOLD: cfg_next.quiet_threshold = pwdata[THR_W-1:0];
                REG_MAX_RUN:   cfg_next.max_quiet_run   = pwdata[RUN_REG_W-1:0];
                REG_CHANNELS:  cfg_next.channels_in_use = pwdata[CHAN_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quiet_threshold <= THRESHOLD_RESET;
            cfg_reg.max_quiet_run   <= MAX_RUN_RESET;
            cfg_reg.channels_in_use <= CHANNELS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.quiet_threshold);
            REG_MAX_RUN:   prdata = APB_DATA_W'(cfg_reg.max_quiet_run);
            REG_CHANNELS:  prdata = APB_DATA_W'(cfg_reg.channels_in_use);
            default:       prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/long_silence_remover_unit.sv */
// ----------------------------------------------------------------------------
// long_silence_remover_unit
// Drops quiet runs of stereo frames that are longer than a set limit.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Request content
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: sample_ch0, sample_ch1
//  m_axis   | out       | tuser: end_of_stream; tdata: out_ch0, out_ch1
//  APB      | in        | quiet_threshold @0x0, max_quiet_run @0x4,
//           |           | channels_in_use @0x8
//
//  One request is accepted per cycle. Its result, if any, is shown on m_axis
//  in the next cycle, after the registered read port of the frame ring.
//  A stalled output holds its request and stops input acceptance until it is
//  taken; s_axis_tready follows m_axis_tready while the output register is full.
//  Reset clears pointers, counters and run state at once; the ring contents
//  are left as they are, since an entry is only read after it was written.
//
// Operation. A pushed frame is quiet when any tested channel has a magnitude
// below quiet_threshold. Kept frames are written to a ring memory of MAX_RUN+1
// entries. The oldest frame leaves once the ring holds more than the limit,
// so each run is settled before any of its frames is seen downstream. When a
// quiet run grows past the limit, its frames still in the ring are removed by
// stepping the write pointer back, and the rest of the run is discarded.
// Drain requests empty the ring one frame at a time, then report end of
// stream with zero samples.
//
// All bookkeeping (pointers, fill count, run length) is resolved in the
// accept cycle. The ring read for the emitted frame is issued in the same
// cycle; when it hits the entry being written in that cycle, the incoming
// frame is forwarded from a holding register instead.
// ----------------------------------------------------------------------------
module long_silence_remover_unit
    import lsr_pkg::*;
#(
    parameter  int MAX_RUN     = MAX_RUN_DEFAULT,
    parameter  int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    localparam int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // sample_ch0, sample_ch1
    input  logic                  s_axis_tuser,   // command
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,   // out_ch0, out_ch1
    output logic                  m_axis_tuser    // end_of_stream
);

    localparam int DEPTH   = MAX_RUN + 1;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LIM_W   = (CNT_W > RUN_REG_W) ? CNT_W : RUN_REG_W;
    localparam int CMP_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int FRAME_W = 2 * SAMPLE_BITS;

    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(MAX_RUN);
    localparam logic [LIM_W-1:0] MAX_LIM_C = LIM_W'(MAX_RUN);

    lsr_cfg_t cfg;

    lsr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Control state.
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic             prev_quiet_reg, prev_quiet_next;
    logic             dropping_reg, dropping_next;

    // Output stage.
    logic               out_valid_reg, out_valid_next;
    logic               out_eos_reg;
    logic               byp_sel_reg;
    logic [FRAME_W-1:0] byp_data_reg;
    logic [FRAME_W-1:0] rd_data_reg;

    // Ring memory.
    logic [FRAME_W-1:0] ring_mem [DEPTH];

    logic                          in_fire;
    logic                          is_drain;
    logic signed [SAMPLE_BITS-1:0] smp0, smp1;
    logic [SAMPLE_BITS-1:0]        mag0, mag1;
    logic                          quiet;
    logic [FRAME_W-1:0]            frame;
    logic [LIM_W-1:0]              lim_wide;
    logic [CNT_W-1:0]              lim;

    logic [CNT_W-1:0] run_base;
    logic             drop_base;
    logic [CNT_W-1:0] run_inc;
    logic [CNT_W-1:0] held;
    logic [PTR_W-1:0] held_mod;
    logic [PTR_W:0]   wp_diff;
    logic [PTR_W-1:0] wp_trim;

    logic             do_store;
    logic             do_trim;
    logic [PTR_W-1:0] rp_mid;
    logic [PTR_W-1:0] wp_mid;
    logic [CNT_W-1:0] cnt_mid;
    logic             emit;
    logic             eos;
    logic             wr_en;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign is_drain      = (s_axis_tuser == CMD_DRAIN);

    assign smp0  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign smp1  = s_axis_tdata[FRAME_W-1:SAMPLE_BITS];
    assign frame = s_axis_tdata[FRAME_W-1:0];

    // Magnitude of the most negative code is 2^(N-1), which fits unsigned N bits.
    assign mag0 = smp0[SAMPLE_BITS-1] ? (~smp0 + 1'b1) : smp0;
    assign mag1 = smp1[SAMPLE_BITS-1] ? (~smp1 + 1'b1) : smp1;

    always_comb
    begin
        quiet = CMP_W'(mag0) < CMP_W'(cfg.quiet_threshold);
        if ((cfg.channels_in_use != CHANNELS_MONO)
            && (CMP_W'(mag1) < CMP_W'(cfg.quiet_threshold)))
        begin
            quiet = 1'b1;
        end
    end

    // Effective limit: the register value, capped at the ring size minus one.
    assign lim_wide = (LIM_W'(cfg.max_quiet_run) > MAX_LIM_C) ? MAX_LIM_C
                                                               : LIM_W'(cfg.max_quiet_run);
    assign lim      = lim_wide[CNT_W-1:0];

    // Quiet run bookkeeping; a loud frame in between restarts the run.
    assign run_base  = prev_quiet_reg ? run_reg : '0;
    assign drop_base = prev_quiet_reg && dropping_reg;
    assign run_inc   = (run_base < DEPTH_C) ? run_base + 1'b1 : run_base;

    // Frames of the run still buffered, removed from the ring tail.
    assign held     = ((run_inc - 1'b1) > count_reg) ? count_reg : (run_inc - 1'b1);
    assign held_mod = (held == DEPTH_C) ? '0 : held[PTR_W-1:0];
    assign wp_diff  = (PTR_W+1)'(wr_ptr_reg) - (PTR_W+1)'(held_mod);
    assign wp_trim  = wp_diff[PTR_W] ? PTR_W'(wp_diff + (PTR_W+1)'(DEPTH))
                                     : wp_diff[PTR_W-1:0];

    always_comb
    begin
        run_next        = run_reg;
        dropping_next   = dropping_reg;
        prev_quiet_next = prev_quiet_reg;
        do_store        = 1'b0;
        do_trim         = 1'b0;
        if (in_fire && !is_drain)
        begin
            prev_quiet_next = quiet;
            if (!quiet)
            begin
                run_next      = '0;
                dropping_next = 1'b0;
                do_store      = 1'b1;
            end
            else
            begin
                run_next      = run_inc;
                dropping_next = drop_base;
                if (!drop_base)
                begin
                    if (run_inc > lim)
                    begin
                        do_trim       = 1'b1;
                        dropping_next = 1'b1;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
            end
        end
    end

    // Ring pointers and fill count after storing or trimming.
    always_comb
    begin
        rp_mid  = rd_ptr_reg;
        wp_mid  = wr_ptr_reg;
        cnt_mid = count_reg;
        if (do_trim)
        begin
            wp_mid  = wp_trim;
            cnt_mid = count_reg - held;
        end
        else if (do_store)
        begin
            wp_mid = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (count_reg == DEPTH_C)
            begin
                // A full ring loses its oldest frame.
                rp_mid = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            else
            begin
                cnt_mid = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        emit = 1'b0;
        eos  = 1'b0;
        if (in_fire)
        begin
            if (is_drain)
            begin
                emit = (count_reg != '0);
                eos  = (count_reg == '0);
            end
            else
            begin
                emit = (cnt_mid > lim);
            end
        end
    end

    assign rd_en   = emit;
    assign rd_addr = rp_mid;
    assign wr_en   = do_store;

    always_comb
    begin
        rd_ptr_next = rp_mid;
        wr_ptr_next = wp_mid;
        count_next  = cnt_mid;
        if (emit)
        begin
            rd_ptr_next = (rp_mid == LAST_PTR) ? '0 : rp_mid + 1'b1;
            count_next  = cnt_mid - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = emit || eos;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            run_reg        <= '0;
            prev_quiet_reg <= 1'b0;
            dropping_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            count_reg      <= count_next;
            run_reg        <= run_next;
            prev_quiet_reg <= prev_quiet_next;
            dropping_reg   <= dropping_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result selection; the read and the write of one entry in one cycle forward.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_eos_reg  <= eos;
            byp_sel_reg  <= wr_en && (rd_addr == wr_ptr_reg);
            byp_data_reg <= frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_ptr_reg] <= frame;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_comb
    begin
        if (out_eos_reg)
        begin
            m_axis_tdata = '0;
        end
        else if (byp_sel_reg)
        begin
            m_axis_tdata = DATA_W'(byp_data_reg);
        end
        else
        begin
            m_axis_tdata = DATA_W'(rd_data_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_eos_reg;

endmodule

/* hw/rtl/lsr_checker.sv */
// ----------------------------------------------------------------------------
// lsr_port_props
// Port-level checks of the long silence remover, bound to the top level.
// ----------------------------------------------------------------------------
module lsr_port_props
    import lsr_pkg::*;
#(
    parameter int DATA_W = 48
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser
);

    // A result that is not taken stays with the same content.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output request changed while stalled");

    // No new request enters while a finished result is still waiting.
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // Every drain request yields a result in the next cycle.
    a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_DRAIN) |=> m_axis_tvalid)
        else $error("drain request gave no result");

    // The end marker carries zero samples.
    a_eos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
        else $error("end of stream with nonzero samples");

endmodule

bind long_silence_remover_unit lsr_port_props #(.DATA_W(DATA_W)) u_lsr_port_props
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
